/* hw/rtl/sbct_pkg.sv */
`timescale 1ns / 1ps
package sbct_pkg;

    localparam int STACK_DEPTH_DEF = 6;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int IN_W       = 192;
    localparam int OUT_W      = 120;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int EXT_W      = 31;
    localparam int EPS_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPS    = 3'd3;

    localparam logic [EXT_W-1:0] HALF_RESET = 31'd65536;
    localparam logic [EPS_W-1:0] EPS_RESET  = 16'd64;
    localparam logic [16:0]      FRAC_UNITY = 17'h10000;

    typedef enum logic [2:0] {
        NODE_PX, NODE_PY, NODE_PZ, NODE_NX, NODE_NY, NODE_NZ, NODE_EMPTY, NODE_SOLID
    } node_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NODE, ST_CLASS, ST_PREP, ST_DIV, ST_PUSH, ST_MUL, ST_ADD, ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       set_empty;
        logic       set_back;
        logic       prep;
        logic       div_init;
        logic       div_step;
        logic       push;
        logic       mul;
        logic       add;
        logic       split_next;
        logic       pop;
        logic       out_load;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic node_plane;
        logic node_empty;
        logic depth_nz;
        logic both_front;
        logic both_back;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic node_t back_child(node_t n);
        return (n == NODE_NZ) ? NODE_SOLID : node_t'(n + 3'd1);
    endfunction

endpackage

/* hw/rtl/sbct_ctrl.sv */
`timescale 1ns / 1ps
module sbct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sbct_pkg::sts_t    sts,
    output sbct_pkg::cmd_t    cmd
);

    sbct_pkg::state_t state_reg, state_next;
    logic [1:0]       lane_reg, lane_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbct_pkg::ST_IDLE;
            lane_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        case (state_reg)
            sbct_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = sbct_pkg::ST_NODE;
            end
            sbct_pkg::ST_NODE: begin
                if (sts.node_plane) state_next = sbct_pkg::ST_CLASS;
                else if (!(sts.node_empty && sts.depth_nz)) state_next = sbct_pkg::ST_FINISH;
            end
            sbct_pkg::ST_CLASS: begin
                if (sts.both_front || sts.both_back) state_next = sbct_pkg::ST_NODE;
                else state_next = sbct_pkg::ST_PREP;
            end
            sbct_pkg::ST_PREP: state_next = sbct_pkg::ST_DIV;
            sbct_pkg::ST_DIV: begin
                if (sts.div_done) state_next = sbct_pkg::ST_PUSH;
            end
            sbct_pkg::ST_PUSH: begin
                state_next = sbct_pkg::ST_MUL;
                lane_next  = 2'd0;
            end
            sbct_pkg::ST_MUL: state_next = sbct_pkg::ST_ADD;
            sbct_pkg::ST_ADD: begin
                if (lane_reg == 2'd3) begin
                    state_next = sbct_pkg::ST_NODE;
                end else begin
                    state_next = sbct_pkg::ST_MUL;
                    lane_next  = lane_reg + 2'd1;
                end
            end
            sbct_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = sbct_pkg::ST_IDLE;
            end
            default: state_next = sbct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.lane = lane_reg;
        s_tready = 1'b0;
        case (state_reg)
            sbct_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sbct_pkg::ST_NODE: begin
                cmd.eval = sts.node_plane;
                cmd.pop  = !sts.node_plane && sts.node_empty && sts.depth_nz;
            end
            sbct_pkg::ST_CLASS: begin
                cmd.set_empty = sts.both_front;
                cmd.set_back  = sts.both_back;
                cmd.prep      = !sts.both_front && !sts.both_back;
            end
            sbct_pkg::ST_PREP: cmd.div_init = 1'b1;
            sbct_pkg::ST_DIV:  cmd.div_step = !sts.div_done;
            sbct_pkg::ST_PUSH: cmd.push = 1'b1;
            sbct_pkg::ST_MUL:  cmd.mul = 1'b1;
            sbct_pkg::ST_ADD: begin
                cmd.add        = 1'b1;
                cmd.split_next = (lane_reg == 2'd3);
            end
            sbct_pkg::ST_FINISH: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/sbct_dp.sv */
`timescale 1ns / 1ps
module sbct_dp #(
    parameter int STACK_DEPTH = sbct_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = sbct_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sbct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbct_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [sbct_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbct_pkg::OUT_W-1:0]        m_tdata,
    output logic                              m_tuser,
    input  sbct_pkg::cmd_t                    cmd,
    output sbct_pkg::sts_t                    sts
);

    localparam int FW      = FRAC_BITS + 1;
    localparam int DW      = 36;
    localparam int MW      = 34;
    localparam int PW      = MW + FW;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);
    localparam int SH_R    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_L    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [FW-1:0] F_ONE = FW'(1) << FRAC_BITS;

    // configuration
    logic [sbct_pkg::EXT_W-1:0] hx_reg, hy_reg, hz_reg;
    logic [sbct_pkg::EPS_W-1:0] eps_reg;

    // walk state
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] p2_reg [3];
    logic signed [31:0] goal_reg [3];
    logic [FW-1:0]      fs_reg, fg_reg, f_reg;
    sbct_pkg::node_t    node_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [FW-1:0]      stk_frac_reg [STACK_DEPTH];
    logic signed [31:0] stk_pt_reg   [STACK_DEPTH][3];
    sbct_pkg::node_t    stk_node_reg [STACK_DEPTH];
    logic               stk_rear_reg [STACK_DEPTH];

    logic signed [DW-1:0] d1_reg, d2_reg, num_reg, den_reg;
    logic [DW-1:0]        ad_reg, rem_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 zero_reg, sat_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;

    logic                 m_tvalid_reg;
    logic                 hit_reg;
    logic signed [31:0]   end_reg [3];
    logic [16:0]          efrac_reg;

    // plane distances of the current node
    logic signed [31:0]   p1a, p2a;
    logic [sbct_pkg::EXT_W-1:0] h_sel;
    logic                 side_neg;
    logic signed [DW-1:0] p1e, p2e, he, d1_c, d2_c;

    always_comb begin
        p1a      = p1_reg[0];
        p2a      = p2_reg[0];
        h_sel    = hx_reg;
        side_neg = 1'b0;
        case (node_reg)
            sbct_pkg::NODE_PX, sbct_pkg::NODE_NX: begin
                p1a = p1_reg[0]; p2a = p2_reg[0]; h_sel = hx_reg;
            end
            sbct_pkg::NODE_PY, sbct_pkg::NODE_NY: begin
                p1a = p1_reg[1]; p2a = p2_reg[1]; h_sel = hy_reg;
            end
            sbct_pkg::NODE_PZ, sbct_pkg::NODE_NZ: begin
                p1a = p1_reg[2]; p2a = p2_reg[2]; h_sel = hz_reg;
            end
            default: begin
                p1a = p1_reg[0]; p2a = p2_reg[0]; h_sel = hx_reg;
            end
        endcase
        case (node_reg)
            sbct_pkg::NODE_NX, sbct_pkg::NODE_NY, sbct_pkg::NODE_NZ: side_neg = 1'b1;
            default: side_neg = 1'b0;
        endcase
        p1e  = DW'(p1a);
        p2e  = DW'(p2a);
        he   = $signed(DW'(h_sel));
        d1_c = (side_neg ? -p1e : p1e) - he;
        d2_c = (side_neg ? -p2e : p2e) - he;
    end

    // divider step and final fraction
    logic [DW-1:0]        rem2;
    logic                 ge;
    logic [FW-1:0]        f_final;
    logic signed [DW-1:0] eps_e;
    logic [DW-1:0]        an_c, ad_c;

    assign eps_e   = $signed(DW'(eps_reg));
    assign rem2    = {rem_reg[DW-2:0], 1'b0};
    assign ge      = (rem2 >= ad_reg);
    assign f_final = zero_reg ? '0 : (sat_reg ? F_ONE : {1'b0, q_reg});
    assign an_c    = num_reg[DW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign ad_c    = den_reg[DW-1] ? $unsigned(-den_reg) : $unsigned(den_reg);

    // interpolation lane
    logic signed [MW-1:0] diff_c, base_c, sc_c, sum_c;
    logic [MW-1:0]        mag_c;

    always_comb begin
        case (cmd.lane)
            2'd0: begin
                diff_c = MW'(p2_reg[0]) - MW'(p1_reg[0]);
                base_c = MW'(p1_reg[0]);
            end
            2'd1: begin
                diff_c = MW'(p2_reg[1]) - MW'(p1_reg[1]);
                base_c = MW'(p1_reg[1]);
            end
            2'd2: begin
                diff_c = MW'(p2_reg[2]) - MW'(p1_reg[2]);
                base_c = MW'(p1_reg[2]);
            end
            default: begin
                diff_c = $signed(MW'(fg_reg)) - $signed(MW'(fs_reg));
                base_c = $signed(MW'(fs_reg));
            end
        endcase
        mag_c = diff_c[MW-1] ? $unsigned(-diff_c) : $unsigned(diff_c);
        sc_c  = $signed(MW'(prod_reg >> FRAC_BITS));
        sum_c = base_c + (neg_reg ? -sc_c : sc_c);
    end

    // stack top
    logic [DEPTH_W-1:0] depth_m1;
    logic [IDX_W-1:0]   top, wr_at;
    assign depth_m1 = depth_reg - 1'b1;
    assign top      = depth_m1[IDX_W-1:0];
    assign wr_at    = depth_reg[IDX_W-1:0];

    logic stack_room;
    assign stack_room = (depth_reg < DEPTH_W'(STACK_DEPTH));

    // output fraction rescale
    logic [FW+SH_L-1:0] fs_wide;
    assign fs_wide = (FW + SH_L)'(fs_reg) << SH_L;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hx_reg  <= sbct_pkg::HALF_RESET;
            hy_reg  <= sbct_pkg::HALF_RESET;
            hz_reg  <= sbct_pkg::HALF_RESET;
            eps_reg <= sbct_pkg::EPS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sbct_pkg::REG_HALF_X: hx_reg  <= cfg_wr_data;
                sbct_pkg::REG_HALF_Y: hy_reg  <= cfg_wr_data;
                sbct_pkg::REG_HALF_Z: hz_reg  <= cfg_wr_data;
                sbct_pkg::REG_EPS:    eps_reg <= cfg_wr_data[sbct_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg     <= sbct_pkg::NODE_EMPTY;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                node_reg  <= sbct_pkg::NODE_PX;
                depth_reg <= '0;
            end
            if (cmd.set_empty) node_reg <= sbct_pkg::NODE_EMPTY;
            if (cmd.set_back)  node_reg <= sbct_pkg::back_child(node_reg);
            if (cmd.push && stack_room) depth_reg <= depth_reg + 1'b1;
            if (cmd.split_next)
                node_reg <= d1_reg[DW-1] ? sbct_pkg::back_child(node_reg)
                                         : sbct_pkg::NODE_EMPTY;
            if (cmd.pop) begin
                depth_reg <= depth_m1;
                node_reg  <= stk_rear_reg[top] ? sbct_pkg::back_child(stk_node_reg[top])
                                               : sbct_pkg::NODE_EMPTY;
            end
            if (cmd.out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                p1_reg[i]   <= s_tdata[32*i +: 32];
                p2_reg[i]   <= s_tdata[96 + 32*i +: 32];
                goal_reg[i] <= s_tdata[96 + 32*i +: 32];
            end
            fs_reg <= '0;
            fg_reg <= F_ONE;
        end
        if (cmd.eval) begin
            d1_reg <= d1_c;
            d2_reg <= d2_c;
        end
        if (cmd.prep) begin
            num_reg <= d1_reg[DW-1] ? d1_reg + eps_e : d1_reg - eps_e;
            den_reg <= d1_reg - d2_reg;
        end
        if (cmd.div_init) begin
            ad_reg   <= ad_c;
            rem_reg  <= an_c;
            q_reg    <= '0;
            zero_reg <= (num_reg == '0) || (num_reg[DW-1] != den_reg[DW-1]);
            sat_reg  <= (an_c >= ad_c);
            // a fixed result needs no iterations
            if ((num_reg == '0) || (num_reg[DW-1] != den_reg[DW-1]) || (an_c >= ad_c))
                cnt_reg <= CNT_W'(FRAC_BITS);
            else
                cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? rem2 - ad_reg : rem2;
            q_reg   <= {q_reg[FRAC_BITS-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.push) begin
            f_reg <= f_final;
            if (stack_room) begin
                stk_frac_reg[wr_at] <= fg_reg;
                for (int i = 0; i < 3; i++) stk_pt_reg[wr_at][i] <= p2_reg[i];
                stk_node_reg[wr_at] <= node_reg;
                stk_rear_reg[wr_at] <= !d1_reg[DW-1];
            end
        end
        if (cmd.mul) begin
            prod_reg <= PW'(mag_c) * PW'(f_reg);
            neg_reg  <= diff_c[MW-1];
        end
        if (cmd.add) begin
            case (cmd.lane)
                2'd0:    p2_reg[0] <= sum_c[31:0];
                2'd1:    p2_reg[1] <= sum_c[31:0];
                2'd2:    p2_reg[2] <= sum_c[31:0];
                default: fg_reg    <= sum_c[FW-1:0];
            endcase
        end
        if (cmd.pop) begin
            fs_reg <= fg_reg;
            fg_reg <= stk_frac_reg[top];
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= p2_reg[i];
                p2_reg[i] <= stk_pt_reg[top][i];
            end
        end
        if (cmd.out_load) begin
            hit_reg <= (node_reg == sbct_pkg::NODE_SOLID);
            for (int i = 0; i < 3; i++)
                end_reg[i] <= (node_reg == sbct_pkg::NODE_SOLID) ? p1_reg[i] : goal_reg[i];
            efrac_reg <= (node_reg == sbct_pkg::NODE_SOLID) ? 17'(fs_wide >> SH_R)
                                                             : sbct_pkg::FRAC_UNITY;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {7'd0, efrac_reg, end_reg[2], end_reg[1], end_reg[0]};

    assign sts.node_plane = (node_reg != sbct_pkg::NODE_EMPTY) &&
                            (node_reg != sbct_pkg::NODE_SOLID);
    assign sts.node_empty = (node_reg == sbct_pkg::NODE_EMPTY);
    assign sts.depth_nz   = (depth_reg != '0);
    assign sts.both_front = !d1_reg[DW-1] && !d2_reg[DW-1];
    assign sts.both_back  = d1_reg[DW-1] && d2_reg[DW-1];
    assign sts.div_done   = (cnt_reg == CNT_W'(FRAC_BITS));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

endmodule

/* hw/rtl/segment_box_clip_trace.sv */
`timescale 1ns / 1ps
// segment against origin-centered box trace, Q16.16 fixed point
// input beats on s_*: one segment (start and goal) per beat
// result beats on m_*: hit flag in m_tuser, end point and end fraction in m_tdata
// box half sizes and split epsilon are written through cfg_wr_en / cfg_index /
// cfg_wr_data while the block is idle; the values stick until the next write
// one segment is worked on at a time; s_tready is high only when idle
// per plane visit the node is evaluated and classified; a piece that is split
// also runs the divider (one quotient bit per cycle), pushes onto the stack while
// there is room, then one shared multiplier does four interpolations; an empty
// node pops the stack while it is not empty; a clipped or saturated split skips
// the divider loop; m_tvalid rises in the same cycle as s_tready goes high again
// for the next segment
// reset restores the default box (half size 1.0) and epsilon, drops any work
// in flight and clears m_tvalid
// the result sits in an output register: a new segment is accepted while it
// waits, and only the final step of the next segment stalls on m_tready
module segment_box_clip_trace #(
    parameter int STACK_DEPTH = sbct_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = sbct_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sbct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbct_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // start_x, start_y, start_z, goal_x, goal_y, goal_z
    input  logic [sbct_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // end_x, end_y, end_z, end_fraction, zero fill
    output logic [sbct_pkg::OUT_W-1:0]        m_tdata,
    // hit
    output logic                              m_tuser
);

    sbct_pkg::cmd_t cmd;
    sbct_pkg::sts_t sts;

    sbct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbct_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

/* hw/rtl/sbct_checker.sv */
`timescale 1ns / 1ps
module sbct_props (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [sbct_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second segment taken while one is in work");

    a_miss_fraction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[112:96] == sbct_pkg::FRAC_UNITY)
        else $error("miss without unit end fraction");

endmodule

bind segment_box_clip_trace sbct_props u_sbct_props (.*);
